// ----- rtl/signed64_integer_alu_core_macros.svh -----
// assertion macros used by the alu rtl
`ifndef SIGNED64_INTEGER_ALU_CORE_MACROS_SVH
`define SIGNED64_INTEGER_ALU_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked while out of reset
`define S64_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked also through reset
`define S64_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define S64_ASSERT(lbl, prop, msg)
`define S64_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/s64alu_pkg.sv -----
// types and codes of the signed 64-bit integer alu
package s64alu_pkg;

  localparam int DATA_WIDTH_DEF = 64;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_MAD   = 4'd3;
  localparam logic [3:0] OP_SAD   = 4'd4;
  localparam logic [3:0] OP_DIV   = 4'd5;
  localparam logic [3:0] OP_REM   = 4'd6;
  localparam logic [3:0] OP_ABS   = 4'd7;
  localparam logic [3:0] OP_NEG   = 4'd8;
  localparam logic [3:0] OP_MIN   = 4'd9;
  localparam logic [3:0] OP_MAX   = 4'd10;
  localparam logic [3:0] OP_BFIND = 4'd11;
  localparam logic [3:0] OP_CVT   = 4'd12;
  localparam logic [3:0] OP_SELP  = 4'd13;
  localparam logic [3:0] OP_SETP  = 4'd14;

  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_NE = 3'd1;
  localparam logic [2:0] CMP_LT = 3'd2;
  localparam logic [2:0] CMP_LE = 3'd3;
  localparam logic [2:0] CMP_GT = 3'd4;
  localparam logic [2:0] CMP_GE = 3'd5;

  localparam logic [3:0] TYPE_U8   = 4'd0;
  localparam logic [3:0] TYPE_U32  = 4'd2;
  localparam logic [3:0] TYPE_S64  = 4'd7;
  localparam logic [3:0] TYPE_PRED = 4'd8;

  localparam logic [1:0] ERR_OK          = 2'd0;
  localparam logic [1:0] ERR_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ERR_DIVZERO     = 2'd2;

  localparam logic [63:0] NO_BIT_FOUND = 64'd4294967295;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic signed [63:0] operand_c;
    logic               product_half;
    logic [2:0]         convert_target;
    logic [2:0]         compare_cond;
  } req_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic [3:0]  result_type;
    logic [1:0]  error_code;
  } rsp_t;

  // per-instruction control that rides along the pipe
  typedef struct packed {
    logic [3:0]  opcode;
    logic [63:0] res;
    logic [3:0]  rtype;
    logic [1:0]  err;
    logic        half;
    logic        neg_q;
    logic        neg_r;
  } ctl_t;

endpackage

// ----- rtl/signed64_integer_alu_core.sv -----
// signed integer alu with a fully pipelined multiplier and divider
// Fully pipelined signed integer execution unit. One instruction may be
// transferred in every cycle in which req_stall is low. Each gives exactly
// one result, whatever the opcode. The pipe depth is set by the restoring
// divider, which resolves one quotient bit per stage. Every other operation
// rides along the same pipe, so results leave in order. The multiplier forms
// four 32x32 partial products in the first stage and sums them over the next
// two. It picks the product half and the mad addend in the fourth. A result
// waiting on a stalled output holds the whole pipe: req_stall is high
// exactly while rsp_valid is high and rsp_stall is high. Operands are taken
// as the sign extension of their low DATA_WIDTH bits. Arithmetic results
// wrap to DATA_WIDTH bits and are sign extended.
`include "signed64_integer_alu_core_macros.svh"

module signed64_integer_alu_core #(
  parameter int DATA_WIDTH = s64alu_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  s64alu_pkg::req_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output s64alu_pkg::rsp_t  rsp
);

  localparam int W  = DATA_WIDTH;
  localparam int SH = 64 - W;

  // wrap to W bits and sign extend to 64
  function automatic logic [63:0] sxw(input logic [63:0] x);
    logic signed [63:0] t;
    t = $signed(x << SH);
    return 64'(t >>> SH);
  endfunction

  // whole pipe moves together unless the output holds a stalled result
  logic adv;
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;

  // stage 0 decode
  logic [63:0] a, b, c, mag_a, mag_b;
  logic        a_neg, b_neg, lt_ab, lt_ba;
  s64alu_pkg::ctl_t ctl_in;

  always_comb begin
    a = sxw(req.operand_a);
    b = sxw(req.operand_b);
    c = sxw(req.operand_c);
    a_neg = a[63];
    b_neg = b[63];
    mag_a = a_neg ? (64'd0 - a) : a;
    mag_b = b_neg ? (64'd0 - b) : b;
    lt_ab = $signed(a) < $signed(b);
    lt_ba = $signed(b) < $signed(a);
    ctl_in.opcode = req.opcode;
    ctl_in.res    = '0;
    ctl_in.rtype  = s64alu_pkg::TYPE_S64;
    ctl_in.err    = s64alu_pkg::ERR_OK;
    ctl_in.half   = req.product_half;
    ctl_in.neg_q  = a_neg ^ b_neg;
    ctl_in.neg_r  = a_neg;
    unique case (req.opcode)
      s64alu_pkg::OP_ADD:   ctl_in.res = sxw(a + b);
      s64alu_pkg::OP_SUB:   ctl_in.res = sxw(a - b);
      s64alu_pkg::OP_MUL,
      s64alu_pkg::OP_MAD:   ctl_in.res = '0;
      s64alu_pkg::OP_SAD:   ctl_in.res = lt_ab ? (b - a) : (a - b);
      s64alu_pkg::OP_DIV,
      s64alu_pkg::OP_REM: begin
        if (b == 64'd0) ctl_in.err = s64alu_pkg::ERR_DIVZERO;
      end
      s64alu_pkg::OP_ABS:   ctl_in.res = sxw(mag_a);
      s64alu_pkg::OP_NEG:   ctl_in.res = sxw(64'd0 - a);
      s64alu_pkg::OP_MIN:   ctl_in.res = lt_ab ? a : b;
      s64alu_pkg::OP_MAX:   ctl_in.res = lt_ba ? a : b;
      s64alu_pkg::OP_BFIND: ctl_in.rtype = s64alu_pkg::TYPE_U32;
      s64alu_pkg::OP_CVT: begin
        ctl_in.rtype = {1'b0, req.convert_target};
        unique case (req.convert_target[1:0])
          2'd0: ctl_in.res = req.convert_target[2] ? {{56{a[7]}}, a[7:0]}
                                                    : {56'd0, a[7:0]};
          2'd1: ctl_in.res = req.convert_target[2] ? {{48{a[15]}}, a[15:0]}
                                                    : {48'd0, a[15:0]};
          2'd2: ctl_in.res = req.convert_target[2] ? {{32{a[31]}}, a[31:0]}
                                                    : {32'd0, a[31:0]};
          default: ctl_in.res = a;
        endcase
      end
      s64alu_pkg::OP_SELP:  ctl_in.res = (c != 64'd0) ? a : b;
      s64alu_pkg::OP_SETP: begin
        ctl_in.rtype = s64alu_pkg::TYPE_PRED;
        unique case (req.compare_cond)
          s64alu_pkg::CMP_EQ: ctl_in.res = {63'd0, a == b};
          s64alu_pkg::CMP_NE: ctl_in.res = {63'd0, a != b};
          s64alu_pkg::CMP_LT: ctl_in.res = {63'd0, lt_ab};
          s64alu_pkg::CMP_LE: ctl_in.res = {63'd0, !lt_ba};
          s64alu_pkg::CMP_GT: ctl_in.res = {63'd0, lt_ba};
          s64alu_pkg::CMP_GE: ctl_in.res = {63'd0, !lt_ab};
          default:            ctl_in.err = s64alu_pkg::ERR_UNSUPPORTED;
        endcase
      end
      default: begin
        ctl_in.rtype = s64alu_pkg::TYPE_U8;
        ctl_in.err   = s64alu_pkg::ERR_UNSUPPORTED;
      end
    endcase
  end

  // pipe registers: stage k holds the divider after k quotient bits
  logic             valid [0:W];
  s64alu_pkg::ctl_t ctl   [0:W];
  logic [W-1:0]     rem   [0:W];
  logic [W-1:0]     quo   [0:W];
  logic [W-1:0]     dvs   [0:W-1];

  // multiplier side registers
  logic [63:0]  a0, c0, c1, c2;
  logic [63:0]  p_ll, p_lh, p_hl, p_hh, corr;
  logic [96:0]  low_sum;
  logic [63:0]  hi_part;
  logic [127:0] prod;

  // next values
  s64alu_pkg::ctl_t ctl_next [1:W];
  logic [W-1:0]     rem_next [1:W];
  logic [W-1:0]     quo_next [1:W];
  logic [63:0]      bf_val, bf_pos, mul_sel;

  always_comb begin
    logic [W:0] t;
    logic [W:0] d;
    logic       ge;
    bf_val   = a0[63] ? ~a0 : a0;
    bf_pos   = s64alu_pkg::NO_BIT_FOUND;
    for (int j = 0; j < 64; j++) begin
      if (bf_val[j]) begin
        bf_pos   = 64'(j);
      end
    end
    mul_sel = sxw(64'(ctl[2].half ? (prod >> W) : prod));
    for (int k = 1; k <= W; k++) begin
      // one restoring division step
      t  = {rem[k-1], quo[k-1][W-1]};
      d  = t - {1'b0, dvs[k-1]};
      ge = t >= {1'b0, dvs[k-1]};
      rem_next[k] = ge ? d[W-1:0] : t[W-1:0];
      quo_next[k] = {quo[k-1][W-2:0], ge};
      ctl_next[k] = ctl[k-1];
      if (k == 1) begin
        if (ctl[0].opcode == s64alu_pkg::OP_SAD) ctl_next[k].res = sxw(ctl[0].res + c0);
        if (ctl[0].opcode == s64alu_pkg::OP_BFIND) ctl_next[k].res = bf_pos;
      end
      if (k == 3) begin
        if (ctl[2].opcode == s64alu_pkg::OP_MUL) ctl_next[k].res = mul_sel;
        if (ctl[2].opcode == s64alu_pkg::OP_MAD) ctl_next[k].res = sxw(mul_sel + c2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= W; k++) valid[k] <= 1'b0;
    end else if (adv) begin
      valid[0] <= req_valid;
      for (int k = 1; k <= W; k++) valid[k] <= valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[0] <= ctl_in;
      rem[0] <= '0;
      quo[0] <= mag_a[W-1:0];
      dvs[0] <= mag_b[W-1:0];
      for (int k = 1; k <= W; k++) begin
        ctl[k] <= ctl_next[k];
        rem[k] <= rem_next[k];
        quo[k] <= quo_next[k];
      end
      for (int k = 1; k < W; k++) dvs[k] <= dvs[k-1];
      // signed product as unsigned partials minus the sign corrections
      a0      <= a;
      c0      <= c;
      p_ll    <= 64'(a[31:0]) * 64'(b[31:0]);
      p_lh    <= 64'(a[31:0]) * 64'(b[63:32]);
      p_hl    <= 64'(a[63:32]) * 64'(b[31:0]);
      p_hh    <= 64'(a[63:32]) * 64'(b[63:32]);
      corr    <= (a_neg ? b : 64'd0) + (b_neg ? a : 64'd0);
      c1      <= c0;
      low_sum <= 97'(p_ll) + {1'b0, p_lh, 32'd0} + {1'b0, p_hl, 32'd0};
      hi_part <= p_hh - corr;
      c2      <= c1;
      prod    <= 128'(low_sum) + {hi_part, 64'd0};
    end
  end

  // last stage: fix the divider signs and register the result
  s64alu_pkg::rsp_t rsp_next;
  logic [63:0]      q_ext, r_ext;

  always_comb begin
    q_ext = 64'(quo[W]);
    r_ext = 64'(rem[W]);
    rsp_next.result_bits = ctl[W].res;
    rsp_next.result_type = ctl[W].rtype;
    rsp_next.error_code  = ctl[W].err;
    if (ctl[W].err == s64alu_pkg::ERR_OK) begin
      if (ctl[W].opcode == s64alu_pkg::OP_DIV) begin
        rsp_next.result_bits = sxw(ctl[W].neg_q ? (64'd0 - q_ext) : q_ext);
      end else if (ctl[W].opcode == s64alu_pkg::OP_REM) begin
        rsp_next.result_bits = sxw(ctl[W].neg_r ? (64'd0 - r_ext) : r_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= valid[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) rsp <= rsp_next;
  end

  `S64_ASSERT(a_hold_pipe, (rsp_valid && rsp_stall) |=> $stable(valid[W]) && $stable(ctl[W]), "pipe moved under a stalled result")
  `S64_ASSERT(a_divzero_zero, (rsp_valid && rsp.error_code == s64alu_pkg::ERR_DIVZERO) |-> (rsp.result_bits == 64'd0 && rsp.result_type == s64alu_pkg::TYPE_S64), "divide by zero result not cleared")
  `S64_ASSERT(a_pred_bit, (rsp_valid && rsp.result_type == s64alu_pkg::TYPE_PRED) |-> (rsp.result_bits[63:1] == 63'd0), "predicate result wider than one bit")
  `S64_ASSERT_ALWAYS(a_reset_empty, rst |=> !rsp_valid, "result valid right after reset")

endmodule
